FILE: hdl/mase_pkg.sv
// shared types and constants for the matrix add/subtract/multiply engine
`timescale 1ns / 1ps
`default_nettype none

package mase_pkg;

  localparam int IDX_W      = 3;
  localparam int COUNT_W    = 4;
  localparam int VALUE_W    = 32;
  localparam int OPCODE_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OPCODE_W-1:0] OP_WRITE_A = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_B = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SUB     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_MUL     = 3'd4;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NOT_SQUARE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          result_row;
    logic [IDX_W-1:0]          result_col;
    logic signed [VALUE_W-1:0] result_value;
    logic                      status;
    logic                      last_element;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             err_load;
    logic             mul;
    logic             sub;
    logic             first;
    logic             last_term;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic elem_done;
  } dp_status_t;

  // travels with each term down the datapath pipeline
  typedef struct packed {
    logic             vld;
    logic             mul;
    logic             sub;
    logic             first;
    logic             last_term;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } dp_tag_t;

endpackage

`default_nettype wire

FILE: hdl/mase_ctrl.sv
// control state machine: decodes items, holds counts, sequences element reads
`timescale 1ns / 1ps
`default_nettype none

module mase_ctrl
  import mase_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dp_status_t            status,
  output dp_cmd_t                    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_ERR} state_t;

  localparam logic [COUNT_W-1:0] DIM = COUNT_W'(MAX_DIM);

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] row_count_r, row_count_nxt;
  logic [COUNT_W-1:0] col_count_r, col_count_nxt;
  logic [COUNT_W-1:0] nr_r, nr_nxt;
  logic [COUNT_W-1:0] nc_r, nc_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               mul_r, mul_nxt;
  logic               sub_r, sub_nxt;

  logic [COUNT_W-1:0] nr_used, nc_used;
  logic               in_fire, in_range;
  logic               last_row, last_col, last_k;

  function automatic logic [COUNT_W-1:0] used_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] u;
    if (c == '0) begin
      u = COUNT_W'(1);
    end else if (c > DIM) begin
      u = DIM;
    end else begin
      u = c;
    end
    return u;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign nr_used  = used_count(row_count_r);
  assign nc_used  = used_count(col_count_r);
  assign in_range = (COUNT_W'(in_data.row_index) < DIM) &&
                    (COUNT_W'(in_data.col_index) < DIM);
  assign last_row = (COUNT_W'(i_r) + COUNT_W'(1)) == nr_r;
  assign last_col = (COUNT_W'(j_r) + COUNT_W'(1)) == nc_r;
  assign last_k   = (COUNT_W'(k_r) + COUNT_W'(1)) == nr_r;

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    nr_nxt        = nr_r;
    nc_nxt        = nc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    mul_nxt       = mul_r;
    sub_nxt       = sub_r;

    cmd           = '0;
    cmd.mul       = mul_r;
    cmd.sub       = sub_r;
    cmd.row       = i_r;
    cmd.col       = j_r;
    cmd.k         = k_r;
    cmd.first     = (k_r == '0);
    cmd.last_term = !mul_r || last_k;
    cmd.last_elem = last_row && last_col;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_count_nxt = cfg_data;
        CFG_COL_COUNT: col_count_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_WRITE_A: cmd.wr_a = in_range;
            OP_WRITE_B: cmd.wr_b = in_range;
            OP_ADD, OP_SUB, OP_MUL: begin
              nr_nxt  = nr_used;
              nc_nxt  = nc_used;
              i_nxt   = '0;
              j_nxt   = '0;
              k_nxt   = '0;
              mul_nxt = (in_data.opcode == OP_MUL);
              sub_nxt = (in_data.opcode == OP_SUB);
              if ((in_data.opcode == OP_MUL) && (nr_used != nc_used)) begin
                state_nxt = S_ERR;
              end else begin
                state_nxt = S_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        if ((k_r != '0) || status.out_free) begin
          cmd.rd_en = 1'b1;
          if (cmd.last_term) begin
            state_nxt = S_DRAIN;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      S_DRAIN: begin
        if (status.elem_done) begin
          k_nxt = '0;
          if (last_row && last_col) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
            if (last_col) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.err_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= COUNT_RESET;
      col_count_r <= COUNT_RESET;
      nr_r        <= COUNT_RESET;
      nc_r        <= COUNT_RESET;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      mul_r       <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      nr_r        <= nr_nxt;
      nc_r        <= nc_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      mul_r       <= mul_nxt;
      sub_r       <= sub_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mase_datapath.sv
// datapath: matrix stores, add/sub and multiply-accumulate pipeline, output register
`timescale 1ns / 1ps
`default_nettype none

module mase_datapath
  import mase_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire dp_cmd_t    cmd,
  input  wire logic       out_ready,
  output logic            out_valid,
  output out_item_t       out_data,
  output dp_status_t      status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [DEPTH];

  logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
  logic signed [63:0]    wr_ext;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  dp_tag_t               tag1_r, tag2_r, tag3_r;

  logic [63:0]           a64, b64;
  logic [63:0]           pp0_nxt, pp0_r;
  logic [31:0]           pp1_nxt, pp1_r;
  logic [31:0]           pp2_nxt, pp2_r;
  logic [DATA_WIDTH-1:0] as_nxt, as_r;

  logic [63:0]           mul_full;
  logic [DATA_WIDTH-1:0] term_nxt, term_r;

  logic [DATA_WIDTH-1:0] acc_r, acc_sum;
  logic [63:0]           acc_sum64;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    int a;
    a = int'(r) * MAX_DIM + int'(c);
    return AW'(a);
  endfunction

  assign wr_addr   = addr_of(in_data.row_index, in_data.col_index);
  assign wr_ext    = 64'($signed(in_data.element_value));
  assign wr_data   = wr_ext[DATA_WIDTH-1:0];
  assign rd_addr_a = cmd.mul ? addr_of(cmd.row, cmd.k) : addr_of(cmd.row, cmd.col);
  assign rd_addr_b = cmd.mul ? addr_of(cmd.k, cmd.col) : addr_of(cmd.row, cmd.col);

  // stores
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem_a[rd_addr_a];
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  // partial products and add/sub
  assign a64     = 64'(rd_a_r);
  assign b64     = 64'(rd_b_r);
  assign pp0_nxt = a64[31:0] * b64[31:0];
  assign pp1_nxt = a64[31:0] * b64[63:32];
  assign pp2_nxt = a64[63:32] * b64[31:0];
  assign as_nxt  = tag1_r.sub ? (rd_a_r - rd_b_r) : (rd_a_r + rd_b_r);

  // combine
  assign mul_full = pp0_r + {pp1_r + pp2_r, 32'd0};
  assign term_nxt = tag2_r.mul ? mul_full[DATA_WIDTH-1:0] : as_r;

  // accumulate
  assign acc_sum   = tag3_r.first ? term_r : (acc_r + term_r);
  assign acc_sum64 = 64'(acc_sum);

  always_ff @(posedge clk) begin
    pp0_r  <= pp0_nxt;
    pp1_r  <= pp1_nxt;
    pp2_r  <= pp2_nxt;
    as_r   <= as_nxt;
    term_r <= term_nxt;
    if (tag3_r.vld) begin
      acc_r <= acc_sum;
    end
    if (cmd.err_load) begin
      out_data_r.result_row   <= '0;
      out_data_r.result_col   <= '0;
      out_data_r.result_value <= '0;
      out_data_r.status       <= STATUS_NOT_SQUARE;
      out_data_r.last_element <= 1'b1;
    end else if (tag3_r.vld && tag3_r.last_term) begin
      out_data_r.result_row   <= tag3_r.row;
      out_data_r.result_col   <= tag3_r.col;
      out_data_r.result_value <= acc_sum64[VALUE_W-1:0];
      out_data_r.status       <= STATUS_OK;
      out_data_r.last_element <= tag3_r.last_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      tag3_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag1_r.vld       <= cmd.rd_en;
      tag1_r.mul       <= cmd.mul;
      tag1_r.sub       <= cmd.sub;
      tag1_r.first     <= cmd.first;
      tag1_r.last_term <= cmd.last_term;
      tag1_r.last_elem <= cmd.last_elem;
      tag1_r.row       <= cmd.row;
      tag1_r.col       <= cmd.col;
      tag2_r           <= tag1_r;
      tag3_r           <= tag2_r;
      if (cmd.err_load || (tag3_r.vld && tag3_r.last_term)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.elem_done = tag3_r.vld && tag3_r.last_term;

endmodule

`default_nettype wire

FILE: hdl/matrix_add_sub_mul_engine.sv
// top level of the matrix add/subtract/multiply engine
//
//   channel   ports                               moves
//   input     in_valid, in_ready, in_data         one write or command item
//   result    out_valid, out_ready, out_data      one result element item
//   config    cfg_we, cfg_index, cfg_data         row_count / col_count write
//
// a write item is stored as it is accepted. a command emits its elements one at
// a time; each term passes the read registers, the partial-product and add/sub
// registers and the term register. add/subtract has one term per element,
// multiply n multiply-accumulates; a refused multiply emits one error item.
// a new element starts only once the output register is free, so out_ready low
// stalls the walk. reset clears control and sets both counts to 8; the stores
// are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_add_sub_mul_engine
  import mase_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mase_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mase_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

`default_nettype wire
